>>> rtl/round_robin_schedule_evaluator_macros.svh
// Assertion macros for the round robin schedule evaluator.
`ifndef ROUND_ROBIN_SCHEDULE_EVALUATOR_MACROS_SVH
`define ROUND_ROBIN_SCHEDULE_EVALUATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lbl failed");
// Next-cycle implication checked outside reset.
`define RRS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lbl failed");
`endif

>>> rtl/rrse_pkg.sv
// Package: sizes and types of the round robin schedule evaluator.
package rrse_pkg;
    localparam int MAX_PROCS = 16;
    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam logic [15:0] QUANTUM_RESET = 16'd4;
    typedef logic [IW-1:0] t_idx;
    typedef logic [CW-1:0] t_cnt;
endpackage

>>> rtl/round_robin_schedule_evaluator.sv
// Top level: round robin scheduling evaluator with load, sort, simulate and emit phases.
//
// Channel  | Dir | Handshake                 | Payload
// s_axis   | in  | s_axis_tvalid/tready      | tdata {burst,arrival}, tlast last_process
// cfg      | in  | i_cfg_valid/o_cfg_ready   | quantum (16 bit)
// m_axis   | out | m_axis_tvalid/tready      | tdata {wait,tat,burst,arrival,number}, tlast
//
// Loading takes one cycle per process. The closing item starts a bubble sort
// of n*(n-1)/2 compare steps, then a simulation whose every turn is a pop, a
// slice, an n-process scan and a requeue, with an idle scan when the queue runs
// dry, then one result per cycle while not stalled. Reset is synchronous, active
// low, and clears control state only. The input is not ready from the closing
// item until the last result is taken.
`include "round_robin_schedule_evaluator_macros.svh"
module round_robin_schedule_evaluator import rrse_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // arrival_time[15:0], burst_time[31:16]
    input  logic         s_axis_tlast,   // last_process
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [15:0]  i_cfg_data,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // process_number[4:0], arrival[20:5],
                                         // burst[36:21], turnaround[68:37],
                                         // waiting[100:69], zero fill
    output logic         m_axis_tlast    // last_result
);
    typedef enum logic [2:0] {
        S_LOAD, S_SORT, S_START, S_POP, S_SCAN, S_AFTER, S_IDLE_SCAN, S_EMIT
    } t_state;

    t_state r_state;
    logic [15:0] r_quantum;
    logic [15:0] r_arr [MAX_PROCS];
    logic [15:0] r_bur [MAX_PROCS];
    logic [15:0] r_rem [MAX_PROCS];
    logic [31:0] r_tat [MAX_PROCS];
    t_idx        r_num [MAX_PROCS];
    t_idx        r_ring [MAX_PROCS];
    logic [MAX_PROCS-1:0] r_queued;
    t_idx r_head;
    t_cnt r_count;
    t_cnt r_loaded;
    logic [31:0] r_time;
    t_idx r_i;       // scan / sort position
    t_cnt r_pass;    // sort pass
    t_idx r_cur;     // process in the current turn
    logic r_out_valid;

    logic [15:0] q_eff;
    logic [15:0] run_len;
    t_idx tail;
    assign q_eff   = (r_quantum == 16'd0) ? 16'd1 : r_quantum;
    assign run_len = (r_rem[r_cur] < q_eff) ? r_rem[r_cur] : q_eff;
    assign tail    = t_idx'(r_head + r_count[IW-1:0]);

    assign s_axis_tready = (r_state == S_LOAD);
    assign o_cfg_ready   = i_rst_n;
    assign m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_quantum <= QUANTUM_RESET;
            r_queued <= '0;
            r_head <= '0;
            r_count <= '0;
            r_loaded <= '0;
            r_time <= '0;
            r_i <= '0;
            r_pass <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_quantum <= i_cfg_data;
            unique case (r_state)
                S_LOAD: begin
                    if (s_axis_tvalid) begin
                        if (r_loaded < t_cnt'(MAX_PROCS)) begin
                            r_arr[r_loaded[IW-1:0]] <= s_axis_tdata[15:0];
                            r_bur[r_loaded[IW-1:0]] <= s_axis_tdata[31:16];
                            r_rem[r_loaded[IW-1:0]] <= s_axis_tdata[31:16];
                            r_tat[r_loaded[IW-1:0]] <= '0;
                            r_num[r_loaded[IW-1:0]] <= r_loaded[IW-1:0];
                            r_loaded <= t_cnt'(r_loaded + 1'b1);
                        end
                        if (s_axis_tlast) begin
                            r_state <= S_SORT;
                            r_i <= '0;
                            r_pass <= '0;
                        end
                    end
                end
                S_SORT: begin
                    // one compare-and-swap per cycle
                    if (t_cnt'(r_pass + 1'b1) >= r_loaded) begin
                        r_state <= S_START;
                    end else if (t_cnt'({1'b0, r_i} + 1'b1) >= t_cnt'(r_loaded - r_pass)) begin
                        r_i <= '0;
                        r_pass <= t_cnt'(r_pass + 1'b1);
                    end else begin
                        if (r_arr[r_i] > r_arr[t_idx'(r_i + 1'b1)]) begin
                            r_arr[r_i] <= r_arr[t_idx'(r_i + 1'b1)];
                            r_arr[t_idx'(r_i + 1'b1)] <= r_arr[r_i];
                            r_bur[r_i] <= r_bur[t_idx'(r_i + 1'b1)];
                            r_bur[t_idx'(r_i + 1'b1)] <= r_bur[r_i];
                            r_rem[r_i] <= r_rem[t_idx'(r_i + 1'b1)];
                            r_rem[t_idx'(r_i + 1'b1)] <= r_rem[r_i];
                            r_num[r_i] <= r_num[t_idx'(r_i + 1'b1)];
                            r_num[t_idx'(r_i + 1'b1)] <= r_num[r_i];
                        end
                        r_i <= t_idx'(r_i + 1'b1);
                    end
                end
                S_START: begin
                    r_time <= {16'd0, r_arr[0]};
                    r_ring[r_head] <= '0;
                    r_queued[0] <= 1'b1;
                    r_count <= t_cnt'(1);
                    r_state <= S_POP;
                end
                S_POP: begin
                    if (r_count == '0) begin
                        r_state <= S_EMIT;
                        r_i <= '0;
                        r_out_valid <= 1'b1;
                    end else begin
                        r_cur <= r_ring[r_head];
                        r_queued[r_ring[r_head]] <= 1'b0;
                        r_head <= t_idx'(r_head + 1'b1);
                        r_count <= t_cnt'(r_count - 1'b1);
                        r_state <= S_SCAN;
                        r_i <= '0;
                    end
                end
                S_SCAN: begin
                    // apply the slice; the arrival scan follows
                    r_state <= S_AFTER;
                    r_rem[r_cur] <= 16'(r_rem[r_cur] - run_len);
                    r_time <= r_time + {16'd0, run_len};
                end
                S_AFTER: begin
                    if (r_i != r_cur && r_rem[r_i] != 16'd0 &&
                        {16'd0, r_arr[r_i]} <= r_time && !r_queued[r_i] &&
                        t_cnt'({1'b0, r_i}) < r_loaded) begin
                        r_ring[tail] <= r_i;
                        r_queued[r_i] <= 1'b1;
                        r_count <= t_cnt'(r_count + 1'b1);
                    end
                    if (t_cnt'({1'b0, r_i} + 1'b1) >= r_loaded) begin
                        r_state <= S_IDLE_SCAN;
                        r_i <= '0;
                    end else begin
                        r_i <= t_idx'(r_i + 1'b1);
                    end
                end
                S_IDLE_SCAN: begin
                    // re-queue or retire the current process, then jump if idle
                    if (r_i == '0 && r_pass != t_cnt'(MAX_PROCS)) begin
                        if (r_rem[r_cur] != 16'd0) begin
                            r_ring[tail] <= r_cur;
                            r_queued[r_cur] <= 1'b1;
                            r_count <= t_cnt'(r_count + 1'b1);
                            r_state <= S_POP;
                        end else begin
                            r_tat[r_cur] <= r_time - {16'd0, r_arr[r_cur]};
                            if (r_count != '0) r_state <= S_POP;
                            else r_pass <= t_cnt'(MAX_PROCS);
                        end
                    end else if (r_rem[r_i] != 16'd0) begin
                        if ({16'd0, r_arr[r_i]} > r_time) r_time <= {16'd0, r_arr[r_i]};
                        r_ring[tail] <= r_i;
                        r_queued[r_i] <= 1'b1;
                        r_count <= t_cnt'(r_count + 1'b1);
                        r_pass <= '0;
                        r_i <= '0;
                        r_state <= S_POP;
                    end else if (t_cnt'({1'b0, r_i} + 1'b1) >= r_loaded) begin
                        r_pass <= '0;
                        r_i <= '0;
                        r_state <= S_POP;
                    end else begin
                        r_i <= t_idx'(r_i + 1'b1);
                    end
                end
                S_EMIT: begin
                    if (m_axis_tready) begin
                        if (t_cnt'({1'b0, r_i} + 1'b1) >= r_loaded) begin
                            r_out_valid <= 1'b0;
                            r_state <= S_LOAD;
                            r_loaded <= '0;
                            r_queued <= '0;
                            r_head <= '0;
                            r_count <= '0;
                            r_time <= '0;
                            r_i <= '0;
                        end else begin
                            r_i <= t_idx'(r_i + 1'b1);
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    logic [31:0] wait_v;
    assign wait_v = r_tat[r_i] - {16'd0, r_bur[r_i]};
    assign m_axis_tdata = {3'd0, wait_v, r_tat[r_i], r_bur[r_i], r_arr[r_i],
                           5'({1'b0, r_num[r_i]} + 1'b1)};
    assign m_axis_tlast = (t_cnt'({1'b0, r_i} + 1'b1) >= r_loaded);

    `RRS_ASSERT_IMP(a_ready_only_load, s_axis_tready, r_state == S_LOAD)
    `RRS_ASSERT_IMP(a_out_only_emit, m_axis_tvalid, r_state == S_EMIT)
    `RRS_ASSERT_IMP(a_count_bound, 1'b1, r_count <= t_cnt'(MAX_PROCS))
    `RRS_ASSERT_NXT(a_hold_stall, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(r_i))
endmodule

>>> sim/testbench.sv
// Self-checking testbench for the round robin schedule evaluator.
module testbench;
    import rrse_pkg::*;

    typedef struct packed {
        logic [4:0]  number;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [31:0] turnaround;
        logic [31:0] waiting;
        logic        last;
    } t_sched_result;

    typedef struct {
        logic        set_quantum;
        logic [15:0] quantum;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic        last;
        logic        typed;     // single process set: turnaround = burst, no wait
    } t_row;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int DRAIN_CYCLES   = 40;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [31:0]   s_axis_tdata = '0;
    logic          s_axis_tlast = 1'b0;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [15:0]   i_cfg_data = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [103:0]  m_axis_tdata;
    logic          m_axis_tlast;

    round_robin_schedule_evaluator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: quantum and the set being loaded
    logic [15:0]   quantum_shadow = QUANTUM_RESET;
    logic [15:0]   load_arrival [MAX_PROCS];
    logic [15:0]   load_burst   [MAX_PROCS];
    int            load_count = 0;
    t_sched_result expected_results [$];
    int            mismatches = 0;
    int            stall_cycles = 0;
    int            items_sent = 0;
    logic          burst_gaps = 1'b1;

    // Sort the set stably by arrival, simulate round robin, queue one result per process.
    task automatic schedule_set();
        logic [15:0] arr [MAX_PROCS];
        logic [15:0] bst [MAX_PROCS];
        logic [15:0] rem [MAX_PROCS];
        logic [31:0] tat [MAX_PROCS];
        logic [3:0]  num [MAX_PROCS];
        int          ring [MAX_PROCS];
        logic        queued [MAX_PROCS];
        int          head, cnt, n, idx;
        logic [31:0] now, q, slice;
        t_sched_result r;
        n = load_count;
        for (int i = 0; i < n; i++) begin
            arr[i] = load_arrival[i]; bst[i] = load_burst[i]; rem[i] = load_burst[i];
            tat[i] = '0; num[i] = i[3:0]; queued[i] = 1'b0;
        end
        for (int i = 0; i + 1 < n; i++)
            for (int j = 0; j + 1 < n - i; j++)
                if (arr[j] > arr[j+1]) begin
                    {arr[j], arr[j+1]} = {arr[j+1], arr[j]};
                    {bst[j], bst[j+1]} = {bst[j+1], bst[j]};
                    {rem[j], rem[j+1]} = {rem[j+1], rem[j]};
                    {num[j], num[j+1]} = {num[j+1], num[j]};
                end
        q = (quantum_shadow == 16'd0) ? 32'd1 : {16'd0, quantum_shadow};
        now = {16'd0, arr[0]};
        head = 0; cnt = 1; ring[0] = 0; queued[0] = 1'b1;
        while (cnt > 0) begin
            idx = ring[head];
            head = (head + 1) % MAX_PROCS;
            cnt--;
            queued[idx] = 1'b0;
            slice = ({16'd0, rem[idx]} < q) ? {16'd0, rem[idx]} : q;
            rem[idx] = rem[idx] - slice[15:0];
            now = now + slice;
            for (int i = 0; i < n; i++)
                if (i != idx && rem[i] != 0 && {16'd0, arr[i]} <= now && !queued[i]) begin
                    ring[(head + cnt) % MAX_PROCS] = i; cnt++; queued[i] = 1'b1;
                end
            if (rem[idx] != 0) begin
                ring[(head + cnt) % MAX_PROCS] = idx; cnt++; queued[idx] = 1'b1;
            end else
                tat[idx] = now - arr[idx];
            if (cnt == 0)
                for (int i = 0; i < n; i++)
                    if (rem[i] != 0) begin
                        if ({16'd0, arr[i]} > now) now = {16'd0, arr[i]};
                        ring[(head + cnt) % MAX_PROCS] = i; cnt++; queued[i] = 1'b1;
                        break;
                    end
        end
        for (int k = 0; k < n; k++) begin
            r.number = {1'b0, num[k]} + 5'd1;
            r.arrival = arr[k];
            r.burst = bst[k];
            r.turnaround = tat[k];
            r.waiting = tat[k] - {16'd0, bst[k]};
            r.last = (k + 1 == n);
            expected_results.push_back(r);
        end
    endtask

    // Offer one process; record it in the predictor once the transaction completes.
    task automatic send_process(input logic [15:0] arrival, input logic [15:0] burst,
                                input logic last, input logic typed);
        int gap;
        t_sched_result r;
        gap = burst_gaps ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            @(negedge i_clk) s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {burst, arrival};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (load_count < MAX_PROCS) begin
            load_arrival[load_count] = arrival;
            load_burst[load_count] = burst;
            load_count++;
        end
        if (last) begin
            if (typed) begin
                r = '{5'd1, arrival, burst, {16'd0, burst}, 32'd0, 1'b1};
                expected_results.push_back(r);
            end else
                schedule_set();
            load_count = 0;
        end
    endtask

    // Write the quantum once the block is idle.
    task automatic write_quantum(input logic [15:0] value);
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        quantum_shadow = value;
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // Receiver: random hold-off per result, compare against the oldest expectation.
    initial begin
        int wait_cycles;
        t_sched_result exp_r, got;
        forever begin
            wait_cycles = burst_gaps ? $urandom_range(0, 12) : 0;
            if (wait_cycles > 0) begin
                @(negedge i_clk) m_axis_tready <= 1'b0;
                repeat (wait_cycles - 1) @(negedge i_clk);
            end
            @(negedge i_clk) m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = '{m_axis_tdata[4:0], m_axis_tdata[20:5], m_axis_tdata[36:21],
                    m_axis_tdata[68:37], m_axis_tdata[100:69], m_axis_tlast};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r || m_axis_tdata[103:101] !== 3'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp_r, got);
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("round_robin_schedule_evaluator regression: fail");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    // Directed stimulus: extremes, zero burst, zero quantum, idle jump.
    t_row directed [] = '{
        '{1'b0, 16'd0,     16'd0,     16'd1,     1'b1, 1'b1},
        '{1'b1, 16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, 1'b1},
        '{1'b0, 16'd0,     16'd100,   16'd0,     1'b1, 1'b1},
        '{1'b1, 16'd0,     16'd5,     16'd3,     1'b0, 1'b0},
        '{1'b0, 16'd0,     16'd0,     16'd2,     1'b0, 1'b0},
        '{1'b0, 16'd0,     16'd5,     16'd1,     1'b0, 1'b0},
        '{1'b0, 16'd0,     16'd2,     16'd0,     1'b1, 1'b0},
        '{1'b1, 16'd2,     16'd10,    16'd5,     1'b0, 1'b0},
        '{1'b0, 16'd0,     16'd0,     16'd3,     1'b0, 1'b0},
        '{1'b0, 16'd0,     16'd40,    16'd2,     1'b1, 1'b0},
        '{1'b1, 16'd1,     16'd0,     16'd0,     1'b0, 1'b0},
        '{1'b0, 16'd0,     16'd3,     16'd0,     1'b0, 1'b0},
        '{1'b0, 16'd0,     16'd3,     16'd7,     1'b1, 1'b0}
    };

    initial begin
        int set_size, q_pick, wide;
        logic [15:0] q, b, a;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].set_quantum)
                write_quantum(directed[i].quantum);
            send_process(directed[i].arrival, directed[i].burst,
                         directed[i].last, directed[i].typed);
        end

        // Random sets, a fresh quantum before each
        while (items_sent < 360) begin
            q_pick = $urandom_range(0, 9);
            case (q_pick)
                0:       q = 16'd0;
                1, 2:    q = 16'd1;
                3:       q = 16'hFFFF;
                4:       q = 16'($urandom_range(4096, 65535));
                default: q = 16'($urandom_range(2, 8));
            endcase
            write_quantum(q);
            burst_gaps = ($urandom_range(0, 3) != 0);
            set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
                                                   : $urandom_range(1, 16);
            wide = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < set_size; k++) begin
                a = wide ? 16'($urandom) : 16'($urandom_range(0, 300));
                if ($urandom_range(0, 19) == 0)
                    b = 16'd0;
                else if (q != 16'd0 && q >= 16'd4096)
                    b = 16'($urandom_range(1, 65535));
                else
                    b = 16'($urandom_range(1, 200));
                send_process(a, b, k == set_size - 1, 1'b0);
            end
        end

        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("round_robin_schedule_evaluator regression: pass");
        else
            $display("round_robin_schedule_evaluator regression: fail");
        $finish;
    end
endmodule
